// ===== rtl/core/cfba_pkg.sv =====
// Shared types and constants for the circular fractional boxcar average unit.
// Holds the item and result structs, the controller command and status structs,
// the controller states and the derived datapath widths. Depends on nothing.
package cfba_pkg;

	// Sample format and default store depth
	localparam int SAMPLE_BITS     = 24;
	localparam int MAX_SAMPLES_DEF = 1024;

	// Fixed field widths
	localparam int POS_W    = 10;
	localparam int VLEN_W   = 11;
	localparam int WIN_W    = 19;
	localparam int WIN_FRAC = 8;
	localparam int INV_W    = 24;

	// Half count and edge weight
	localparam int H_W  = WIN_W - WIN_FRAC - 1;
	localparam int FW_W = WIN_FRAC + 2;

	// Remainder unit: both dividends share one step count
	localparam int DVD_W     = (POS_W > H_W) ? POS_W : H_W;
	localparam int MOD_CNT_W = $clog2(DVD_W);

	// Accumulation and product widths
	localparam int CNT_IN_W = H_W + 1;
	localparam int EDGE_W   = SAMPLE_BITS + 1;
	localparam int INNER_W  = SAMPLE_BITS + H_W + 1;
	localparam int EPROD_W  = FW_W + 1 + EDGE_W;
	localparam int SUM_W    = INNER_W + WIN_FRAC + 2;
	localparam int LO_W     = 32;
	localparam int MAG_W    = (SUM_W > LO_W) ? SUM_W : LO_W + 1;
	localparam int HI_W     = MAG_W - LO_W;
	localparam int R_W      = HI_W + INV_W;

	// Saturation bounds on the rounded magnitude
	localparam logic [R_W-1:0] SAT_POS = R_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
	localparam logic [R_W-1:0] SAT_NEG = R_W'(64'd1 << (SAMPLE_BITS - 1));

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(512);
	localparam logic [INV_W-1:0] INV_RESET = INV_W'(8388608);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VECTOR_LENGTH = 2'd0,
		REG_WINDOW_WIDTH  = 2'd1,
		REG_INVERSE_WIDTH = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef struct packed {
		op_t                            op;
		logic [POS_W-1:0]               position;
		logic signed [SAMPLE_BITS-1:0]  sample;
	} item_t;

	typedef struct packed {
		logic [POS_W-1:0]               result_position;
		logic signed [SAMPLE_BITS-1:0]  averaged;
	} result_t;

	typedef enum logic [1:0] {
		RD_NONE  = 2'd0,
		RD_EDGE  = 2'd1,
		RD_INNER = 2'd2
	} rd_kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MOD,
		ST_WRITE,
		ST_PTRS,
		ST_RD_LO,
		ST_RD_HI,
		ST_RD_INNER,
		ST_DRAIN,
		ST_SUM,
		ST_MAG,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic mod_start;
		logic mod_step;
		logic wr_en;
		logic ptr_load;
		logic rd_lo;
		logic rd_hi;
		logic rd_inner;
		logic sum_en;
		logic mag_en;
		logic mul_lo_en;
		logic mul_hi_en;
		logic fin_en;
	} dp_cmd_t;

	typedef struct packed {
		logic is_query;
		logic h_zero;
		logic inner_last;
	} dp_stat_t;

endpackage

// ===== rtl/core/circular_fractional_boxcar_average_unit.sv =====
// Top level of the circular fractional boxcar average unit.
// Holds the configuration registers and joins cfba_ctrl and cfba_dp; uses cfba_pkg.
//
// An item is taken when start is high and busy is low. A write item stores its
// sample and frees the block once the remainder unit has reduced its position. A
// query item, with h = floor(w/2), passes through the remainder unit that reduces
// position and h modulo the vector length, a state that forms the edge pointers,
// one sample read per cycle from the single-port sample memory for the 2*h + 1
// window samples (the centre sample twice when h is zero), a state that drains
// the last read, then sum, magnitude, two multiplier passes and rounding. done is
// high for exactly one cycle and result holds its value until the next query
// finishes; the receiver cannot hold it off, and busy is already low while done
// is high. Configuration writes are always ready and must be made only while the
// block is idle.
module circular_fractional_boxcar_average_unit #(
	parameter int MAX_SAMPLES = cfba_pkg::MAX_SAMPLES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  cfba_pkg::item_t                  item,
	output logic                             done,
	output cfba_pkg::result_t                result,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [cfba_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cfba_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import cfba_pkg::*;

	logic [VLEN_W-1:0] vlen_q;
	logic [WIN_W-1:0]  win_q;
	logic [INV_W-1:0]  inv_q;
	dp_cmd_t           cmd;
	dp_stat_t          stat;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vlen_q <= VLEN_W'(MAX_SAMPLES);
			win_q  <= WIN_RESET;
			inv_q  <= INV_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_VECTOR_LENGTH: vlen_q <= cfg_data[VLEN_W-1:0];
				REG_WINDOW_WIDTH:  win_q  <= cfg_data[WIN_W-1:0];
				REG_INVERSE_WIDTH: inv_q  <= cfg_data[INV_W-1:0];
				default: ;
			endcase
		end
	end

	cfba_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	cfba_dp #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.vlen   (vlen_q),
		.win    (win_q),
		.inv    (inv_q),
		.cmd    (cmd),
		.stat   (stat),
		.result (result),
		.done   (done)
	);

endmodule

// ===== rtl/core/cfba_ctrl.sv =====
// Sequencing state machine for the boxcar average unit.
// Issues datapath commands for writes and queries; uses cfba_pkg.
module cfba_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  cfba_pkg::dp_stat_t stat,
	output cfba_pkg::dp_cmd_t  cmd,
	output logic               busy
);
	import cfba_pkg::*;

	state_t                 state_q;
	state_t                 state_nxt;
	logic [MOD_CNT_W-1:0]   mod_cnt_q;
	logic                   mod_last;

	assign mod_last = (mod_cnt_q == MOD_CNT_W'(DVD_W - 1));

	// Hold state and step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			mod_cnt_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_MOD) begin
				mod_cnt_q <= mod_cnt_q + MOD_CNT_W'(1);
			end else begin
				mod_cnt_q <= '0;
			end
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_nxt = ST_MOD;
			end
			ST_MOD: begin
				if (mod_last) state_nxt = stat.is_query ? ST_PTRS : ST_WRITE;
			end
			ST_WRITE:    state_nxt = ST_IDLE;
			ST_PTRS:     state_nxt = ST_RD_LO;
			ST_RD_LO:    state_nxt = ST_RD_HI;
			ST_RD_HI: begin
				state_nxt = stat.h_zero ? ST_DRAIN : ST_RD_INNER;
			end
			ST_RD_INNER: begin
				if (stat.inner_last) state_nxt = ST_DRAIN;
			end
			ST_DRAIN:    state_nxt = ST_SUM;
			ST_SUM:      state_nxt = ST_MAG;
			ST_MAG:      state_nxt = ST_MUL_LO;
			ST_MUL_LO:   state_nxt = ST_MUL_HI;
			ST_MUL_HI:   state_nxt = ST_FIN;
			ST_FIN:      state_nxt = ST_IDLE;
			default:     state_nxt = ST_IDLE;
		endcase
	end

	// Commands to the datapath
	always_comb begin
		cmd           = '0;
		cmd.mod_start = (state_q == ST_IDLE) && start;
		cmd.mod_step  = (state_q == ST_MOD);
		cmd.wr_en     = (state_q == ST_WRITE);
		cmd.ptr_load  = (state_q == ST_PTRS);
		cmd.rd_lo     = (state_q == ST_RD_LO);
		cmd.rd_hi     = (state_q == ST_RD_HI);
		cmd.rd_inner  = (state_q == ST_RD_INNER);
		cmd.sum_en    = (state_q == ST_SUM);
		cmd.mag_en    = (state_q == ST_MAG);
		cmd.mul_lo_en = (state_q == ST_MUL_LO);
		cmd.mul_hi_en = (state_q == ST_MUL_HI);
		cmd.fin_en    = (state_q == ST_FIN);
		busy          = (state_q != ST_IDLE);
	end

endmodule

// ===== rtl/core/cfba_dp.sv =====
// Datapath of the boxcar average unit: remainder unit, sample memory,
// window accumulators, split multiplier and rounding. Uses cfba_pkg.
module cfba_dp #(
	parameter int MAX_SAMPLES = cfba_pkg::MAX_SAMPLES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cfba_pkg::item_t              item,
	input  logic [cfba_pkg::VLEN_W-1:0]  vlen,
	input  logic [cfba_pkg::WIN_W-1:0]   win,
	input  logic [cfba_pkg::INV_W-1:0]   inv,
	input  cfba_pkg::dp_cmd_t            cmd,
	output cfba_pkg::dp_stat_t           stat,
	output cfba_pkg::result_t            result,
	output logic                         done
);
	import cfba_pkg::*;

	localparam int IDX_W = $clog2(MAX_SAMPLES);
	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

	// Captured item and length
	op_t                           op_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic [CNT_W-1:0]              n_q;
	logic [CNT_W-1:0]              n_next;

	// Remainder lanes: position and half count
	logic [DVD_W-1:0] pdvd_q, hdvd_q;
	logic [IDX_W-1:0] prem_q, hrem_q;
	logic [IDX_W:0]   prem_ext, hrem_ext, n_ext;

	// Window pointers
	logic [IDX_W-1:0] lo_q, hi_q, ptr_q;
	logic [IDX_W:0]   lo_sum, hi_sum, lo_inc, ptr_inc;
	logic [IDX_W-1:0] lo_w, hi_w, lo_next, ptr_next;
	logic [CNT_IN_W-1:0] cnt_q;

	// Memory and read stage
	logic [SAMPLE_BITS-1:0]        mem [MAX_SAMPLES];
	logic [IDX_W-1:0]              raddr;
	logic                          rd_en;
	logic signed [SAMPLE_BITS-1:0] rdata_s1;
	rd_kind_t                      rd_kind_s1;

	// Arithmetic
	logic [H_W-1:0]              h;
	logic [FW_W-1:0]             fw;
	logic signed [FW_W:0]        fw_s;
	logic signed [EDGE_W-1:0]    edge_q;
	logic signed [INNER_W-1:0]   inner_q;
	logic signed [EPROD_W-1:0]   eprod;
	logic signed [SUM_W-1:0]     sum_q;
	logic [MAG_W-1:0]            mag_q;
	logic                        neg_q;
	logic [LO_W+INV_W-1:0]       plo_q;
	logic [R_W-1:0]              phi_q;
	logic [R_W:0]                r_sum;
	logic [R_W-1:0]              r;
	logic signed [SAMPLE_BITS-1:0] avg;
	result_t                     result_q;
	logic                        done_q;

	assign h  = win[WIN_W-1:WIN_FRAC+1];
	assign fw = {1'b0, win[WIN_FRAC:0]} + FW_W'(1 << WIN_FRAC);

	// Active length: zero or too large selects the full store
	always_comb begin
		if ((vlen == '0) || (int'(vlen) > MAX_SAMPLES)) begin
			n_next = CNT_W'(MAX_SAMPLES);
		end else begin
			n_next = CNT_W'(vlen);
		end
	end

	// One restoring remainder step per lane
	assign n_ext    = (IDX_W + 1)'(n_q);
	assign prem_ext = {prem_q, pdvd_q[DVD_W-1]};
	assign hrem_ext = {hrem_q, hdvd_q[DVD_W-1]};

	// Capture item, then reduce position and half count modulo n
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_WRITE;
		end else if (cmd.mod_start) begin
			op_q <= item.op;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mod_start) begin
			sample_q <= item.sample;
			n_q      <= n_next;
			pdvd_q   <= DVD_W'(item.position);
			hdvd_q   <= DVD_W'(h);
			prem_q   <= '0;
			hrem_q   <= '0;
		end else if (cmd.mod_step) begin
			pdvd_q <= pdvd_q << 1;
			hdvd_q <= hdvd_q << 1;
			prem_q <= (prem_ext >= n_ext) ? IDX_W'(prem_ext - n_ext) : IDX_W'(prem_ext);
			hrem_q <= (hrem_ext >= n_ext) ? IDX_W'(hrem_ext - n_ext) : IDX_W'(hrem_ext);
		end
	end

	// Edge pointers and wrap of the running pointer
	assign lo_sum   = (IDX_W + 1)'(prem_q) + n_ext - (IDX_W + 1)'(hrem_q);
	assign hi_sum   = (IDX_W + 1)'(prem_q) + (IDX_W + 1)'(hrem_q);
	assign lo_w     = (lo_sum >= n_ext) ? IDX_W'(lo_sum - n_ext) : IDX_W'(lo_sum);
	assign hi_w     = (hi_sum >= n_ext) ? IDX_W'(hi_sum - n_ext) : IDX_W'(hi_sum);
	assign lo_inc   = (IDX_W + 1)'(lo_q) + (IDX_W + 1)'(1);
	assign ptr_inc  = (IDX_W + 1)'(ptr_q) + (IDX_W + 1)'(1);
	assign lo_next  = (lo_inc == n_ext) ? '0 : IDX_W'(lo_inc);
	assign ptr_next = (ptr_inc == n_ext) ? '0 : IDX_W'(ptr_inc);

	always_ff @(posedge clk) begin
		if (cmd.ptr_load) begin
			lo_q  <= lo_w;
			hi_q  <= hi_w;
			cnt_q <= {h, 1'b0} - CNT_IN_W'(1);
		end
		if (cmd.rd_lo) begin
			ptr_q <= lo_next;
		end else if (cmd.rd_inner) begin
			ptr_q <= ptr_next;
			cnt_q <= cnt_q - CNT_IN_W'(1);
		end
	end

	assign stat.is_query   = (op_q == OP_QUERY);
	assign stat.h_zero     = (h == '0);
	assign stat.inner_last = (cnt_q == CNT_IN_W'(1));

	// Sample memory: one write or one read per cycle
	assign rd_en = cmd.rd_lo | cmd.rd_hi | cmd.rd_inner;
	always_comb begin
		if (cmd.rd_lo) begin
			raddr = lo_q;
		end else if (cmd.rd_hi) begin
			raddr = hi_q;
		end else begin
			raddr = ptr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[prem_q] <= sample_q;
		end
		if (rd_en) begin
			rdata_s1 <= mem[raddr];
		end
	end

	// Tag each read so its data lands in the right accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_kind_s1 <= RD_NONE;
		end else if (cmd.rd_lo || cmd.rd_hi) begin
			rd_kind_s1 <= RD_EDGE;
		end else if (cmd.rd_inner) begin
			rd_kind_s1 <= RD_INNER;
		end else begin
			rd_kind_s1 <= RD_NONE;
		end
	end

	// Accumulate edge pair and inner samples
	always_ff @(posedge clk) begin
		if (cmd.ptr_load) begin
			edge_q  <= '0;
			inner_q <= '0;
		end else begin
			case (rd_kind_s1)
				RD_EDGE:  edge_q  <= edge_q + EDGE_W'(rdata_s1);
				RD_INNER: inner_q <= inner_q + INNER_W'(rdata_s1);
				default: ;
			endcase
		end
	end

	// Weighted sum with nine fraction bits, then sign and magnitude
	assign fw_s  = {1'b0, fw};
	assign eprod = fw_s * edge_q;

	always_ff @(posedge clk) begin
		if (cmd.sum_en) begin
			sum_q <= SUM_W'(eprod) + (SUM_W'(inner_q) <<< (WIN_FRAC + 1));
		end
		if (cmd.mag_en) begin
			neg_q <= sum_q[SUM_W-1];
			mag_q <= sum_q[SUM_W-1] ? MAG_W'(~sum_q + SUM_W'(1)) : MAG_W'(sum_q);
		end
		if (cmd.mul_lo_en) begin
			plo_q <= mag_q[LO_W-1:0] * inv;
		end
		if (cmd.mul_hi_en) begin
			phi_q <= mag_q[MAG_W-1:LO_W] * inv;
		end
	end

	// Round half away from zero and saturate
	assign r_sum = (R_W + 1)'(phi_q) + (R_W + 1)'(plo_q[LO_W+INV_W-1:LO_W])
		+ (R_W + 1)'(1);
	assign r     = r_sum[R_W:1];

	always_comb begin
		if (neg_q) begin
			avg = (r > SAT_NEG) ? {1'b1, {(SAMPLE_BITS - 1){1'b0}}}
				: SAMPLE_BITS'(~r + R_W'(1));
		end else begin
			avg = (r > SAT_POS) ? {1'b0, {(SAMPLE_BITS - 1){1'b1}}}
				: SAMPLE_BITS'(r);
		end
	end

	// Register the result position and average as a query finishes
	always_ff @(posedge clk) begin
		if (cmd.fin_en) begin
			result_q.result_position <= POS_W'(prem_q);
			result_q.averaged        <= avg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.fin_en;
		end
	end

	assign result = result_q;
	assign done   = done_q;

endmodule

// ===== rtl/core/cfba_checker.sv =====
// Port-level checks for the boxcar average unit, bound to the top level.
// Sees only the top-level handshake ports; uses nothing else.
module cfba_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	// An accepted item makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	// A result strobe lasts one cycle
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// A result follows work in progress
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without an item in progress");

	// The block is free again when its result shows
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy while presenting a result");

endmodule

bind circular_fractional_boxcar_average_unit cfba_checker u_cfba_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);
